@@ rtl/lcd4_pkg.sv @@
package lcd4_pkg;

    // Display geometry and DDRAM row bases.
    localparam int unsigned COLUMNS = 16;
    localparam logic [7:0] ROW0_BASE = 8'h80;
    localparam logic [7:0] ROW1_BASE = 8'hC0;
    localparam logic [7:0] ROW0_END = 8'(ROW0_BASE + COLUMNS);
    localparam logic [7:0] ROW1_END = 8'(ROW1_BASE + COLUMNS);
    localparam logic [6:0] COLUMN_LIMIT = 7'(COLUMNS);

    // Pauses in microseconds.
    localparam int unsigned WAIT_BYTE_US_I = 40;
    localparam int unsigned WAIT_CLEAR_US_I = 1600;
    localparam int unsigned WAIT_INIT1_US_I = 4000;
    localparam int unsigned WAIT_INIT2_US_I = 100;
    localparam int unsigned WAIT_POWERUP_US_I = 15000;

    localparam logic [13:0] WAIT_BYTE_US = 14'(WAIT_BYTE_US_I);
    localparam logic [13:0] WAIT_CLEAR_US = 14'(WAIT_BYTE_US_I + WAIT_CLEAR_US_I);
    localparam logic [13:0] WAIT_INIT1_US = 14'(WAIT_BYTE_US_I + WAIT_INIT1_US_I);
    localparam logic [13:0] WAIT_INIT2_US = 14'(WAIT_BYTE_US_I + WAIT_INIT2_US_I);
    localparam logic [13:0] WAIT_POWERUP_US = 14'(WAIT_POWERUP_US_I);

    // Controller command bytes.
    localparam logic [7:0] CMD_FUNC_8BIT = 8'h03;
    localparam logic [7:0] CMD_FUNC_4BIT = 8'h02;
    localparam logic [7:0] CMD_FUNC_2LINE = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0E;
    localparam logic [7:0] CMD_CURSOR_SHIFT = 8'h10;

    // Script steps: initialize runs all of them, clear runs the clear pair only.
    localparam logic [3:0] STEP_FIRST = 4'd0;
    localparam logic [3:0] STEP_CLEAR_FIRST = 4'd6;
    localparam logic [3:0] STEP_CLEAR_LAST = 4'd7;
    localparam logic [3:0] STEP_INIT_LAST = 4'd12;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_INIT  = 2'd3
    } op_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        rs;
        logic [13:0] before_us;
        logic [13:0] after_us;
        logic        last;
    } lcd4_byte_t;

    function automatic lcd4_byte_t script_entry(input logic [3:0] idx);
        lcd4_byte_t b;
        b.rs = 1'b0;
        b.before_us = '0;
        b.last = 1'b0;
        b.after_us = WAIT_BYTE_US;
        case (idx)
            4'd0: begin
                b.data = CMD_FUNC_8BIT;
                b.after_us = WAIT_INIT1_US;
            end
            4'd1: begin
                b.data = CMD_FUNC_8BIT;
                b.after_us = WAIT_INIT2_US;
            end
            4'd2: b.data = CMD_FUNC_8BIT;
            4'd3: b.data = CMD_FUNC_4BIT;
            4'd4: b.data = CMD_FUNC_2LINE;
            4'd5: b.data = CMD_DISPLAY_OFF;
            4'd6: begin
                b.data = CMD_CLEAR;
                b.after_us = WAIT_CLEAR_US;
            end
            4'd7: begin
                b.data = ROW0_BASE;
                b.after_us = WAIT_CLEAR_US;
            end
            4'd8: b.data = CMD_ENTRY_MODE;
            4'd9: b.data = ROW0_BASE;
            4'd10: b.data = CMD_DISPLAY_ON;
            4'd11: b.data = CMD_CURSOR_SHIFT;
            default: b.data = ROW0_BASE;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/lcd4_strobe_out.sv @@
module lcd4_strobe_out
    import lcd4_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  lcd4_byte_t  byte_in,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // nibble[3:0], wait_before_us[17:4], wait_after_us[31:18]
    output logic        m_tuser,  // register_select
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        OS_IDLE = 3'b001,
        OS_HI   = 3'b010,
        OS_LO   = 3'b100
    } os_state_t;

    os_state_t   state_reg, state_next;
    lcd4_byte_t  hold_reg, hold_next;
    logic        valid_reg, valid_next;
    logic [31:0] data_reg, data_next;
    logic        user_reg, user_next;
    logic        last_reg, last_next;
    logic        slot_free;

    assign slot_free  = !valid_reg || m_tready;
    assign byte_ready = (state_reg == OS_IDLE);

    always_comb begin
        state_next = state_reg;
        hold_next  = hold_reg;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        case (state_reg)
            OS_IDLE: begin
                if (byte_valid) begin
                    hold_next  = byte_in;
                    state_next = OS_HI;
                end
            end
            OS_HI: begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    data_next  = {14'd0, hold_reg.before_us, hold_reg.data[7:4]};
                    user_next  = hold_reg.rs;
                    last_next  = 1'b0;
                    state_next = OS_LO;
                end
            end
            OS_LO: begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    data_next  = {hold_reg.after_us, 14'd0, hold_reg.data[3:0]};
                    user_next  = hold_reg.rs;
                    last_next  = hold_reg.last;
                    state_next = OS_IDLE;
                end
            end
            default: state_next = OS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= OS_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        hold_reg <= hold_next;
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

@@ rtl/lcd_4bit_command_sequencer.sv @@
// An accepted request passes the request registers (load state), the byte register
// (send state) and the hold and output registers of the nibble output stage; that stage
// takes a byte only while idle. Each byte goes out as two nibble words, and the next byte
// is loaded while they are sent. An out-of-range set-cursor column sends no byte.
// Reset (aresetn low at a clock edge) empties both stages and homes the cursor to row 0.
module lcd_4bit_command_sequencer
    import lcd4_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // char_code[7:0], row[8], column[14:9], zero[15]
    input  logic [1:0]  s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // nibble[3:0], wait_before_us[17:4], wait_after_us[31:18]
    output logic        m_tuser,  // register_select
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_SEND = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    op_t         op_reg, op_next;
    logic [7:0]  char_reg, char_next;
    logic        row_reg, row_next;
    logic [5:0]  col_reg, col_next;
    logic [3:0]  step_reg, step_next;
    logic [7:0]  cursor_reg, cursor_next;
    lcd4_byte_t  byte_reg, byte_next;

    lcd4_byte_t  load_byte;
    logic [7:0]  load_cursor;
    logic        load_skip;
    logic [7:0]  add_a, add_b, sum;
    logic        wrap_row1, wrap_row0;
    logic        byte_ready;

    // One shared adder serves the cursor increment and the set-cursor address.
    assign add_a = (op_reg == OP_SET) ? {1'b1, row_reg, 6'd0} : cursor_reg;
    assign add_b = (op_reg == OP_SET) ? {2'd0, col_reg} : 8'd1;
    assign sum = add_a + add_b;
    assign wrap_row1 = (sum >= ROW0_END) && (sum < ROW1_BASE);
    assign wrap_row0 = (sum >= ROW1_END);

    always_comb begin
        load_byte   = script_entry(step_reg);
        load_cursor = cursor_reg;
        load_skip   = 1'b0;
        case (op_reg)
            OP_WRITE: begin
                load_byte.before_us = '0;
                load_byte.after_us  = WAIT_BYTE_US;
                if (step_reg == STEP_FIRST) begin
                    load_byte.data = char_reg;
                    load_byte.rs   = 1'b1;
                    load_byte.last = !(wrap_row1 || wrap_row0);
                    if (wrap_row1) begin
                        load_cursor = ROW1_BASE;
                    end else if (wrap_row0) begin
                        load_cursor = ROW0_BASE;
                    end else begin
                        load_cursor = sum;
                    end
                end else begin
                    // Second byte moves the controller to the row the cursor wrapped to.
                    load_byte.data = cursor_reg;
                    load_byte.rs   = 1'b0;
                    load_byte.last = 1'b1;
                end
            end
            OP_SET: begin
                load_byte.data      = sum;
                load_byte.rs        = 1'b0;
                load_byte.before_us = '0;
                load_byte.after_us  = WAIT_BYTE_US;
                load_byte.last      = 1'b1;
                if ({1'b0, col_reg} < COLUMN_LIMIT) begin
                    load_cursor = sum;
                end else begin
                    load_skip = 1'b1;
                end
            end
            OP_CLEAR: begin
                load_cursor    = ROW0_BASE;
                load_byte.last = (step_reg == STEP_CLEAR_LAST);
            end
            OP_INIT: begin
                load_cursor    = ROW0_BASE;
                load_byte.last = (step_reg == STEP_INIT_LAST);
                if (step_reg == STEP_FIRST) begin
                    load_byte.before_us = WAIT_POWERUP_US;
                end
            end
            default: load_skip = 1'b1;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        char_next   = char_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        step_next   = step_reg;
        cursor_next = cursor_reg;
        byte_next   = byte_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = op_t'(s_tuser);
                    char_next  = s_tdata[7:0];
                    row_next   = s_tdata[8];
                    col_next   = s_tdata[14:9];
                    step_next  = (op_t'(s_tuser) == OP_CLEAR) ? STEP_CLEAR_FIRST : STEP_FIRST;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (load_skip) begin
                    state_next = ST_IDLE;
                end else begin
                    cursor_next = load_cursor;
                    byte_next   = load_byte;
                    state_next  = ST_SEND;
                end
            end
            ST_SEND: begin
                if (byte_ready) begin
                    if (byte_reg.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        step_next  = step_reg + 4'd1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cursor_reg <= ROW0_BASE;
        end else begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
        end
        op_reg   <= op_next;
        char_reg <= char_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        step_reg <= step_next;
        byte_reg <= byte_next;
    end

    assign s_tready = (state_reg == ST_IDLE);

    lcd4_strobe_out u_strobe_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (state_reg == ST_SEND),
        .byte_ready (byte_ready),
        .byte_in    (byte_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
